@@ src/jet_pkg.sv @@
package jet_pkg;

  localparam int unsigned ZW        = 32;
  localparam int unsigned PW        = 64;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 28;

  localparam logic signed [ZW-1:0] X_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [ZW-1:0] Y_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [ZW-1:0] X_STEP_RST   = 32'sd262144;
  localparam logic signed [ZW-1:0] Y_STEP_RST   = 32'sd262144;
  localparam logic signed [ZW-1:0] C_REAL_RST   = -32'sd187904819;
  localparam logic signed [ZW-1:0] C_IMAG_RST   = 32'sd72483635;
  localparam int unsigned          ITER_LIMIT_RST = 1000;

  localparam logic signed [PW-1:0] SAT_MAX = {{(PW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_X_STEP,
    REG_Y_STEP,
    REG_C_REAL,
    REG_C_IMAG,
    REG_ITER_LIMIT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic mul_init;
    logic mul_en;
    logic load_z;
    logic step_z;
    logic cnt_clr;
    logic cnt_inc;
    logic load_out;
    logic out_max;
  } cmd_t;

  typedef struct packed {
    logic escape;
    logic max_zero;
    logic last;
  } status_t;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    if (v < SAT_MIN) r = SAT_MIN;
    return r[ZW-1:0];
  endfunction

endpackage

@@ src/julia_escape_time_pixel.sv @@
// Julia set escape-time engine for one pixel per item. The pixel (col, row) is
// mapped to z = (x_origin + col*x_step, y_origin + row*y_step), saturated to
// 32-bit Q4.28 (FRAC_BITS fraction bits), and z = z*z + c is iterated until
// |z|^2 > 4 or the iteration limit is reached. The result gives the escape
// iteration (or the limit) and an in-set flag. Each iteration passes through
// ST_MUL, which registers the products of the three 32x32 multipliers, and
// ST_EVAL for the escape compare and update; a zero limit gives the result
// without iterating. Items are worked on one at a time; a finished result sits
// in an output register, so the next item is taken while it waits. Write
// configuration only while idle.
module julia_escape_time_pixel #(
  parameter int unsigned COORD_BITS = jet_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = jet_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jet_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jet_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         pixel_col_i,
  input  logic [COORD_BITS-1:0]         pixel_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jet_pkg::CNT_OUT_W-1:0] iter_count_o,
  output logic                          in_set_o
);
  import jet_pkg::*;

  cmd_t    cmd;
  status_t status;

  jet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  jet_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .iter_count_o (iter_count_o),
    .in_set_o     (in_set_o)
  );

endmodule

@@ src/jet_ctrl.sv @@
module jet_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  jet_pkg::status_t status_i,
  output jet_pkg::cmd_t    cmd_o
);
  import jet_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    can_out = !out_valid_q || out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.mul_en   = 1'b1;
          cmd_o.mul_init = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.max_zero) begin
          if (can_out) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_max  = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.load_z  = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.escape || status_i.last) begin
          if (can_out) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_max  = !status_i.escape;
            out_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.step_z  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/jet_dp.sv @@
module jet_dp #(
  parameter int unsigned COORD_BITS = jet_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = jet_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jet_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [COORD_BITS-1:0]          pixel_col_i,
  input  logic [COORD_BITS-1:0]          pixel_row_i,
  input  jet_pkg::cmd_t                  cmd_i,
  output jet_pkg::status_t               status_o,
  output logic [jet_pkg::CNT_OUT_W-1:0]  iter_count_o,
  output logic                           in_set_o
);
  import jet_pkg::*;

  localparam int unsigned ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam logic [PW-1:0] THRESH = (ESC_SHIFT < PW) ? (PW'(1) << ESC_SHIFT) : '1;

  logic signed [ZW-1:0]   x_origin_q, y_origin_q, x_step_q, y_step_q, c_real_q, c_imag_q;
  logic [COUNT_BITS-1:0]  iter_limit_q;

  logic signed [ZW-1:0]   zx_q, zy_q;
  logic signed [PW-1:0]   p0_q, p1_q, p2_q;
  logic signed [ZW-1:0]   op0a, op0b, op1a, op1b;
  logic signed [PW-1:0]   m0, m1, m2;
  logic [PW-1:0]          sq_sum;
  logic signed [PW-1:0]   re_sh, im_sh;
  logic signed [ZW-1:0]   nx, ny, zx_init, zy_init;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_nx;
  logic [COUNT_BITS-1:0]  count_q;
  logic                   in_set_q;
  logic [CNT_OUT_W+COUNT_BITS-1:0] count_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q   <= X_ORIGIN_RST;
      y_origin_q   <= Y_ORIGIN_RST;
      x_step_q     <= X_STEP_RST;
      y_step_q     <= Y_STEP_RST;
      c_real_q     <= C_REAL_RST;
      c_imag_q     <= C_IMAG_RST;
      iter_limit_q <= COUNT_BITS'(ITER_LIMIT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_ORIGIN:   x_origin_q   <= cfg_data_i;
        REG_Y_ORIGIN:   y_origin_q   <= cfg_data_i;
        REG_X_STEP:     x_step_q     <= cfg_data_i;
        REG_Y_STEP:     y_step_q     <= cfg_data_i;
        REG_C_REAL:     c_real_q     <= cfg_data_i;
        REG_C_IMAG:     c_imag_q     <= cfg_data_i;
        REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // multipliers m0 and m1 are shared: start point mapping, then the squares; m2 gives the cross term
  assign op0a = cmd_i.mul_init ? $signed(ZW'(pixel_col_i)) : zx_q;
  assign op0b = cmd_i.mul_init ? x_step_q : zx_q;
  assign op1a = cmd_i.mul_init ? $signed(ZW'(pixel_row_i)) : zy_q;
  assign op1b = cmd_i.mul_init ? y_step_q : zy_q;
  assign m0   = op0a * op0b;
  assign m1   = op1a * op1b;
  assign m2   = zx_q * zy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p0_q <= m0;
      p1_q <= m1;
      p2_q <= m2;
    end
  end

  assign zx_init = sat32(PW'(x_origin_q) + p0_q);
  assign zy_init = sat32(PW'(y_origin_q) + p1_q);

  assign sq_sum = $unsigned(p0_q) + $unsigned(p1_q);
  assign re_sh  = (p0_q - p1_q) >>> FRAC_BITS;
  assign im_sh  = p2_q >>> (FRAC_BITS - 1);
  assign nx     = sat32(re_sh + PW'(c_real_q));
  assign ny     = sat32(im_sh + PW'(c_imag_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_z) begin
      zx_q <= zx_init;
      zy_q <= zy_init;
    end else if (cmd_i.step_z) begin
      zx_q <= nx;
      zy_q <= ny;
    end
  end

  assign cnt_nx = cnt_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) cnt_q <= '0;
    else if (cmd_i.cnt_inc) cnt_q <= cnt_nx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      count_q  <= cmd_i.out_max ? iter_limit_q : cnt_q;
      in_set_q <= cmd_i.out_max;
    end
  end

  assign status_o.escape   = sq_sum > THRESH;
  assign status_o.max_zero = (iter_limit_q == '0);
  assign status_o.last     = (cnt_nx == iter_limit_q);

  assign count_ext    = {{CNT_OUT_W{1'b0}}, count_q};
  assign iter_count_o = count_ext[CNT_OUT_W-1:0];
  assign in_set_o     = in_set_q;

endmodule

@@ tb/sv/tb_julia_escape_time_pixel.sv @@
module tb_julia_escape_time_pixel;
  import jet_pkg::*;

  localparam int unsigned COORD_W = COORD_BITS_DEF;
  localparam int unsigned FRAC    = FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;
  localparam logic [63:0] ESC_LIMIT = (2 * FRAC + 2 < 64) ? (64'd1 << (2 * FRAC + 2)) : '1;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [COORD_W-1:0] COORD_TOP = '1;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic                 in_set;
  } escape_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 pix_valid  = 1'b0;
  logic                 pix_ready;
  logic [COORD_W-1:0]   pix_col    = '0;
  logic [COORD_W-1:0]   pix_row    = '0;
  logic                 res_valid;
  logic                 res_ready  = 1'b0;
  logic [CNT_OUT_W-1:0] res_count;
  logic                 res_in_set;

  // view and constant as the block holds them
  int                   x_org;
  int                   y_org;
  int                   x_stp;
  int                   y_stp;
  int                   c_re;
  int                   c_im;
  logic [15:0]          iter_lim;

  pixel_t               pixel_queue[$];
  escape_t              due_results[$];
  pixel_t               launch;
  escape_t              want;
  int unsigned          send_gap   = 0;
  int unsigned          recv_stall = 0;
  int unsigned          hold;
  int unsigned          errors     = 0;
  bit                   steady     = 1'b0;

  julia_escape_time_pixel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (pix_valid),
    .in_ready_o   (pix_ready),
    .pixel_col_i  (pix_col),
    .pixel_row_i  (pix_row),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .iter_count_o (res_count),
    .in_set_o     (res_in_set)
  );

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic escape_t escape_time(input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row);
    longint      zx;
    longint      zy;
    longint      sq_x;
    longint      sq_y;
    longint      nx;
    logic [63:0] mag;
    escape_t     r;
    zx = clamp32(longint'(x_org) + longint'(col) * longint'(x_stp));
    zy = clamp32(longint'(y_org) + longint'(row) * longint'(y_stp));
    r.count  = iter_lim;
    r.in_set = 1'b1;
    for (int unsigned i = 0; i < iter_lim; i++) begin
      sq_x = zx * zx;
      sq_y = zy * zy;
      mag  = 64'(sq_x) + 64'(sq_y);
      if (mag > ESC_LIMIT) begin
        r.count  = CNT_OUT_W'(i);
        r.in_set = 1'b0;
        break;
      end
      nx = clamp32(((sq_x - sq_y) >>> FRAC) + longint'(c_re));
      zy = clamp32(((zx * zy) >>> (FRAC - 1)) + longint'(c_im));
      zx = nx;
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  task automatic count_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_X_ORIGIN:   x_org = data;
      REG_Y_ORIGIN:   y_org = data;
      REG_X_STEP:     x_stp = data;
      REG_Y_STEP:     y_stp = data;
      REG_C_REAL:     c_re = data;
      REG_C_IMAG:     c_im = data;
      REG_ITER_LIMIT: iter_lim = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    pixel_queue.push_back('{col: col, row: row});
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || pix_valid || due_results.size() != 0);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? COORD_TOP : '0;
    return COORD_W'($urandom_range(0, 2 ** COORD_W - 1));
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // pixel sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid <= 1'b0;
      send_gap  <= 0;
    end else if (!pix_valid || pix_ready) begin
      if (send_gap != 0) begin
        pix_valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        launch = pixel_queue.pop_front();
        pix_valid <= 1'b1;
        pix_col   <= launch.col;
        pix_row   <= launch.row;
        send_gap  <= idle_len();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      res_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      hold = idle_len();
      if (hold != 0) begin
        res_ready  <= 1'b0;
        recv_stall <= hold - 1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // prediction and check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_valid && pix_ready) due_results.push_back(escape_time(pix_col, pix_row));
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          count_error($sformatf("unexpected result: count %0d in_set %0b",
                                res_count, res_in_set));
        end else begin
          want = due_results.pop_front();
          if (res_count !== want.count || res_in_set !== want.in_set)
            count_error($sformatf("result mismatch: count exp %0d got %0d, in_set exp %0b got %0b",
                                  want.count, res_count, want.in_set, res_in_set));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] stp;
    int unsigned      r;
    x_org    = X_ORIGIN_RST;
    y_org    = Y_ORIGIN_RST;
    x_stp    = X_STEP_RST;
    y_stp    = Y_STEP_RST;
    c_re     = C_REAL_RST;
    c_im     = C_IMAG_RST;
    iter_lim = 16'(ITER_LIMIT_RST);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default view and constant
    add_pixel('0, '0);
    add_pixel(COORD_TOP, COORD_TOP);
    add_pixel(12'd2048, 12'd2048);
    add_pixel(COORD_TOP, '0);
    add_pixel('0, COORD_TOP);
    add_pixel(12'd1536, 12'd2560);
    add_pixel(12'd2560, 12'd1536);
    drain();

    // zero limit skips the loop
    set_reg(REG_ITER_LIMIT, '0);
    add_pixel(12'd2048, 12'd2048);
    add_pixel(COORD_TOP, COORD_TOP);
    drain();

    // start point saturates, unused index ignored
    set_reg(REG_X_ORIGIN, 32'h7FFF_FFFF);
    set_reg(REG_X_STEP, 32'h7FFF_FFFF);
    set_reg(REG_Y_ORIGIN, 32'h8000_0000);
    set_reg(REG_Y_STEP, 32'h8000_0000);
    set_reg(REG_ITER_LIMIT, 32'd1);
    set_reg(REG_NONE, 32'hFFFF_FFFF);
    add_pixel(COORD_TOP, COORD_TOP);
    add_pixel('0, '0);
    add_pixel(12'd1, 12'd4094);
    drain();

    // extreme constants, full limit
    set_reg(REG_X_ORIGIN, '0);
    set_reg(REG_Y_ORIGIN, '0);
    set_reg(REG_X_STEP, '0);
    set_reg(REG_Y_STEP, '0);
    set_reg(REG_C_REAL, 32'h7FFF_FFFF);
    set_reg(REG_C_IMAG, 32'h8000_0000);
    set_reg(REG_ITER_LIMIT, 32'h0000_FFFF);
    add_pixel(12'd7, 12'd9);
    drain();
    set_reg(REG_C_REAL, 32'h8000_0000);
    set_reg(REG_C_IMAG, 32'h7FFF_FFFF);
    add_pixel(COORD_TOP, '0);
    drain();
    set_reg(REG_C_REAL, '0);
    set_reg(REG_C_IMAG, '0);
    add_pixel(12'd123, 12'd456);
    drain();

    // random views and constants
    for (int ph = 0; ph < 8; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        set_reg(REG_X_ORIGIN, $urandom_range(0, 32'h3000_0000) - 32'h2000_0000);
        set_reg(REG_Y_ORIGIN, $urandom_range(0, 32'h3000_0000) - 32'h1800_0000);
        stp = $urandom_range(32'h1000, 32'h10_0000);
        if ($urandom_range(0, 3) == 0) stp = -stp;
        set_reg(REG_X_STEP, stp);
        stp = $urandom_range(32'h1000, 32'h10_0000);
        if ($urandom_range(0, 3) == 0) stp = -stp;
        set_reg(REG_Y_STEP, stp);
        set_reg(REG_C_REAL, $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
        set_reg(REG_C_IMAG, $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
      end else begin
        set_reg(REG_X_ORIGIN, $urandom());
        set_reg(REG_Y_ORIGIN, $urandom());
        set_reg(REG_X_STEP, $urandom());
        set_reg(REG_Y_STEP, $urandom());
        set_reg(REG_C_REAL, $urandom());
        set_reg(REG_C_IMAG, $urandom());
      end
      r = $urandom_range(0, 99);
      if (r < 10) set_reg(REG_ITER_LIMIT, 32'd1);
      else if (r < 85) set_reg(REG_ITER_LIMIT, $urandom_range(2, 64));
      else set_reg(REG_ITER_LIMIT, $urandom_range(65, 255));
      if ($urandom_range(0, 1) == 0) set_reg(REG_NONE, $urandom());
      repeat (75) add_pixel(rand_coord(), rand_coord());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
